FILE: design/iras_pkg.sv
`default_nettype none
package iras_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } iras_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A + {1'b0, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/iras_in_if.sv
`default_nettype none
interface iras_in_if #(parameter int WIDTH = 32) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: design/iras_out_if.sv
`default_nettype none
interface iras_out_if ();
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

FILE: design/iras_ram.sv
`default_nettype none
module iras_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/iras_cfg.sv
`default_nettype none
module iras_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [5:0]  radix
);
  import iras_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_nxt;
  logic [RADIX_W-1:0] wr_raw;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIX);
  assign wr_raw = pwdata[RADIX_W-1:0];

  always_comb begin
    radix_nxt = radix_r;
    if (wr_en) begin
      priority if (wr_raw < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (wr_raw > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = wr_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_RADIX) ? {{(32-RADIX_W){1'b0}}, radix_r} : 32'd0;
  assign radix  = radix_r;

endmodule
`default_nettype wire

FILE: design/iras_div.sv
`default_nettype none
module iras_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [5:0]       divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient,
  output logic      [5:0]       remainder,
  output logic                  quot_zero
);
  import iras_pkg::*;

  localparam int CW = $clog2(WIDTH);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [WIDTH-1:0]   q_r, q_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   diff;
  logic               ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, q_r[WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[WIDTH-2:0], ge};
      rem_nxt = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
  assign quot_zero = (q_r == '0);

endmodule
`default_nettype wire

FILE: design/integer_to_radix_ascii_unit.sv
`default_nettype none
// Converts one signed WIDTH-bit integer per item into ASCII characters in the
// base held in the radix register (2..36, writes clamped, reset 16), most
// significant first, with '-' ahead of negative values and last set on the
// final character. Digits come from a bit-serial divider; they are stacked
// in a small RAM and played back in reverse, each one read from the RAM in
// ST_READ and loaded into the output register in ST_LOAD once the output
// slot is free. The next item is accepted once the last character has been
// loaded into the output register.
module integer_to_radix_ascii_unit #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  iras_in_if.sink          in_ch,
  iras_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import iras_pkg::*;

  localparam int AW = $clog2(WIDTH);
  localparam int PW = $clog2(WIDTH + 1);

  iras_state_t state_r, state_nxt;

  logic [RADIX_W-1:0] radix;
  logic               accept;
  logic               neg_r, neg_nxt;
  logic [PW-1:0]      nd_r, nd_nxt;
  logic [PW-1:0]      nd_m1;
  logic [WIDTH-1:0]   mag;

  logic               div_start;
  logic [WIDTH-1:0]   div_dividend;
  logic               div_done;
  logic [WIDTH-1:0]   div_quot;
  logic [RADIX_W-1:0] div_rem;
  logic               div_qzero;

  logic               ram_we;
  logic               ram_re;
  logic [RADIX_W-1:0] ram_rdata;

  logic               slot_free;
  logic               load_sign;
  logic               load_digit;
  logic               in_ready;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  iras_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix   (radix)
  );

  iras_div #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem),
    .quot_zero (div_qzero)
  );

  iras_ram #(.DW(RADIX_W), .DEPTH(WIDTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nd_r[AW-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (nd_m1[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign nd_m1     = nd_r - PW'(1);
  assign accept    = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign mag       = in_ch.value[WIDTH-1] ? (~in_ch.value + WIDTH'(1)) : in_ch.value;
  assign div_dividend = (state_r == ST_IDLE) ? mag : div_quot;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && div_qzero) state_nxt = neg_r ? ST_SIGN : ST_READ;
      end
      ST_SIGN: begin
        if (slot_free) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) state_nxt = (nd_r == PW'(1)) ? ST_IDLE : ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_ch.valid;
      end
      ST_DIV: begin
        ram_we    = div_done;
        div_start = div_done && !div_qzero;
      end
      ST_SIGN: begin
        load_sign = slot_free;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_LOAD: begin
        load_digit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    neg_nxt = neg_r;
    nd_nxt  = nd_r;
    if (accept) begin
      neg_nxt = in_ch.value[WIDTH-1];
      nd_nxt  = '0;
    end else if (ram_we) begin
      nd_nxt = nd_r + PW'(1);
    end else if (load_digit) begin
      nd_nxt = nd_m1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    priority if (load_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_MINUS;
      out_last_nxt  = 1'b0;
    end else if (load_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = digit_char(ram_rdata);
      out_last_nxt  = (nd_r == PW'(1));
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

endmodule
`default_nettype wire
